>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/scpc_pkg.sv
package scpc_pkg;

    localparam int NUM_SITES     = 20;
    localparam int NUM_CUSTOMERS = 15;
    localparam int COST_BITS     = 8;

    // Fixed field widths of the request and result channels.
    localparam int OP_W        = 2;
    localparam int SITE_IDX_W  = 5;
    localparam int COST_IN_W   = 8;
    localparam int COV_IN_W    = 15;
    localparam int OPEN_BITS   = 20;
    localparam int TOTAL_W     = 14;
    localparam int COUNT_W     = 4;
    localparam int TOTAL_MAX   = 16383;
    localparam int COUNT_MAX   = 15;

    localparam int SITE_AW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
    localparam int CNT_W   = $clog2(NUM_CUSTOMERS + 1);
    localparam int SUM_W   = $clog2(NUM_SITES * ((2 ** COST_BITS) - 1) + 1);
    localparam int PROD_W  = CNT_W + COST_BITS;
    localparam int TOT_W   = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
    localparam int NCHUNK  = (NUM_CUSTOMERS + 7) / 8;
    localparam int COV_PAD = NCHUNK * 8;
    localparam int CHUNK_AW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    localparam logic [OP_W-1:0] OP_LOAD_COST = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_COV  = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_COUNT,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                     cost_en;
        logic                     cov_en;
        logic [SITE_AW-1:0]       addr;
        logic [COST_BITS-1:0]     cost;
        logic [NUM_CUSTOMERS-1:0] cov;
    } t_wr_req;

    typedef struct packed {
        logic               en;
        logic [SITE_AW-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic [COST_BITS-1:0]     cost;
        logic [NUM_CUSTOMERS-1:0] cov;
    } t_rd_data;

    typedef struct packed {
        logic               valid;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } t_result;

    function automatic logic [3:0] popcnt8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/scpc_table.sv
module scpc_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scpc_pkg::t_wr_req   i_wr,
    input  scpc_pkg::t_rd_req   i_rd,
    output scpc_pkg::t_rd_data  o_rd
);

    logic [scpc_pkg::COST_BITS-1:0]     cost_mem [scpc_pkg::NUM_SITES];
    logic [scpc_pkg::NUM_CUSTOMERS-1:0] cov_mem  [scpc_pkg::NUM_SITES];

    // Per-entry written flags; an entry never written reads as zero.
    logic [scpc_pkg::NUM_SITES-1:0] r_cost_vld;
    logic [scpc_pkg::NUM_SITES-1:0] r_cov_vld;

    logic [scpc_pkg::COST_BITS-1:0]     r_rd_cost;
    logic [scpc_pkg::NUM_CUSTOMERS-1:0] r_rd_cov;
    logic                               r_rd_cost_vld;
    logic                               r_rd_cov_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_vld <= '0;
            r_cov_vld  <= '0;
        end else begin
            if (i_wr.cost_en) begin
                r_cost_vld[i_wr.addr] <= 1'b1;
            end
            if (i_wr.cov_en) begin
                r_cov_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.cost_en) begin
            cost_mem[i_wr.addr] <= i_wr.cost;
        end
        if (i_wr.cov_en) begin
            cov_mem[i_wr.addr] <= i_wr.cov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_cost     <= cost_mem[i_rd.addr];
            r_rd_cov      <= cov_mem[i_rd.addr];
            r_rd_cost_vld <= r_cost_vld[i_rd.addr];
            r_rd_cov_vld  <= r_cov_vld[i_rd.addr];
        end
    end

    assign o_rd.cost = r_rd_cost_vld ? r_rd_cost : '0;
    assign o_rd.cov  = r_rd_cov_vld  ? r_rd_cov  : '0;

endmodule

>>> hw/rtl/scpc_eval.sv
module scpc_eval (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [scpc_pkg::OPEN_BITS-1:0]    i_open_mask,
    output logic                              o_busy,
    output scpc_pkg::t_rd_req                 o_rd,
    input  scpc_pkg::t_rd_data                i_rd,
    output scpc_pkg::t_result                 o_res,
    input  logic                              i_res_take
);

    scpc_pkg::t_state r_state;
    scpc_pkg::t_state n_state;

    logic [scpc_pkg::SITE_AW-1:0]   r_addr;
    logic [scpc_pkg::OPEN_BITS-1:0] r_open;
    logic                           r_pend;
    logic                           r_sel;
    logic [scpc_pkg::SUM_W-1:0]     r_sum;
    logic [scpc_pkg::COST_BITS-1:0] r_max;
    logic [scpc_pkg::COV_PAD-1:0]   r_cov;
    logic [scpc_pkg::CNT_W-1:0]     r_ones;
    logic [scpc_pkg::CHUNK_AW-1:0]  r_chunk;
    logic [scpc_pkg::CNT_W-1:0]     r_missing;
    logic [scpc_pkg::PROD_W-1:0]    r_prod;

    logic                           w_last_addr;
    logic                           w_last_chunk;
    logic [scpc_pkg::CNT_W-1:0]     w_missing;
    logic [scpc_pkg::TOT_W-1:0]     w_total;

    assign w_last_addr  = (r_addr == scpc_pkg::SITE_AW'(scpc_pkg::NUM_SITES - 1));
    assign w_last_chunk = (r_chunk == scpc_pkg::CHUNK_AW'(scpc_pkg::NCHUNK - 1));
    assign w_missing    = scpc_pkg::CNT_W'(scpc_pkg::NUM_CUSTOMERS) - r_ones;
    assign w_total      = scpc_pkg::TOT_W'(r_sum) + scpc_pkg::TOT_W'(r_prod);

    always_comb begin
        n_state = r_state;
        case (r_state)
            scpc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = scpc_pkg::ST_SWEEP;
                end
            end
            scpc_pkg::ST_SWEEP: begin
                if (w_last_addr) begin
                    n_state = scpc_pkg::ST_DRAIN;
                end
            end
            scpc_pkg::ST_DRAIN: begin
                n_state = scpc_pkg::ST_COUNT;
            end
            scpc_pkg::ST_COUNT: begin
                if (w_last_chunk) begin
                    n_state = scpc_pkg::ST_MUL;
                end
            end
            scpc_pkg::ST_MUL: begin
                n_state = scpc_pkg::ST_DONE;
            end
            scpc_pkg::ST_DONE: begin
                if (i_res_take) begin
                    n_state = scpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy      = (r_state != scpc_pkg::ST_IDLE);
        o_rd.en     = (r_state == scpc_pkg::ST_SWEEP);
        o_rd.addr   = r_addr;
        o_res.valid = (r_state == scpc_pkg::ST_DONE);
        if (32'(w_total) > 32'(scpc_pkg::TOTAL_MAX)) begin
            o_res.total = scpc_pkg::TOTAL_W'(scpc_pkg::TOTAL_MAX);
        end else begin
            o_res.total = scpc_pkg::TOTAL_W'(w_total);
        end
        if (32'(r_missing) > 32'(scpc_pkg::COUNT_MAX)) begin
            o_res.count = scpc_pkg::COUNT_W'(scpc_pkg::COUNT_MAX);
        end else begin
            o_res.count = scpc_pkg::COUNT_W'(r_missing);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scpc_pkg::ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == scpc_pkg::ST_SWEEP);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            scpc_pkg::ST_IDLE: begin
                r_addr  <= '0;
                r_open  <= i_open_mask;
                r_sum   <= '0;
                r_max   <= '0;
                r_cov   <= '0;
                r_ones  <= '0;
                r_chunk <= '0;
            end
            scpc_pkg::ST_SWEEP: begin
                r_addr <= r_addr + scpc_pkg::SITE_AW'(1);
                r_sel  <= r_open[0];
                r_open <= r_open >> 1;
            end
            scpc_pkg::ST_COUNT: begin
                r_ones  <= r_ones + scpc_pkg::CNT_W'(scpc_pkg::popcnt8(r_cov[7:0]));
                r_cov   <= r_cov >> 8;
                r_chunk <= r_chunk + scpc_pkg::CHUNK_AW'(1);
            end
            scpc_pkg::ST_MUL: begin
                r_missing <= w_missing;
                r_prod    <= scpc_pkg::PROD_W'(w_missing) * scpc_pkg::PROD_W'(r_max);
            end
            default: begin
            end
        endcase

        // Read data arrives in the cycle after the address; fold it in here.
        if (r_pend) begin
            if (i_rd.cost > r_max) begin
                r_max <= i_rd.cost;
            end
            if (r_sel) begin
                r_sum <= r_sum + scpc_pkg::SUM_W'(i_rd.cost);
                r_cov <= r_cov | scpc_pkg::COV_PAD'(i_rd.cov);
            end
        end
    end

endmodule

>>> hw/rtl/set_cover_penalty_cost.sv
// Weighted set-cover penalty cost. The block holds an opening cost and a
// customer-coverage mask for each of NUM_SITES sites, both reading as zero
// until written after reset. A request with op 0 writes one site's cost, op 1
// writes one site's coverage mask; both return nothing, and writes to a site
// index beyond the table are dropped. A request with op 2 carries a mask of
// opened sites and returns one result: the sum of the opened sites' costs plus
// the number of customers that no opened site covers, times the largest cost
// anywhere in the cost table. Op 3 is dropped. An evaluation walks the tables
// one site per cycle through a memory with a registered read port, and holds
// the request channel closed through its sweep, drain, count and multiply steps
// and until its result is taken; the count of covered customers is taken eight
// bits per cycle. The result goes to an output register, so the next request is
// taken while a result waits to be read. Totals saturate at 16383.
`include "assert_macros.svh"

module set_cover_penalty_cost (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [scpc_pkg::OP_W-1:0]           i_op,
    input  logic [scpc_pkg::SITE_IDX_W-1:0]     i_site_index,
    input  logic [scpc_pkg::COST_IN_W-1:0]      i_site_cost,
    input  logic [scpc_pkg::COV_IN_W-1:0]       i_coverage_mask,
    input  logic [scpc_pkg::OPEN_BITS-1:0]      i_open_mask,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [scpc_pkg::TOTAL_W-1:0]        o_total_cost,
    output logic [scpc_pkg::COUNT_W-1:0]        o_uncovered_count
);

    scpc_pkg::t_wr_req  w_wr;
    scpc_pkg::t_rd_req  w_rd;
    scpc_pkg::t_rd_data w_rd_data;
    scpc_pkg::t_result  w_res;

    logic        w_accept;
    logic        w_in_range;
    logic        w_busy;
    logic        w_take;
    logic [31:0] w_idx32;
    logic [31:0] w_cost32;
    logic [63:0] w_cov64;

    logic r_out_valid;
    logic [scpc_pkg::TOTAL_W-1:0] r_total;
    logic [scpc_pkg::COUNT_W-1:0] r_count;

    // The request channel is open whenever no evaluation is in flight.
    assign o_in_ready = !w_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    // Load requests are decoded straight into a table write.
    assign w_idx32    = 32'(i_site_index);
    assign w_cost32   = 32'(i_site_cost);
    assign w_cov64    = 64'(i_coverage_mask);
    assign w_in_range = (w_idx32 < 32'(scpc_pkg::NUM_SITES));

    assign w_wr.cost_en = w_accept && w_in_range && (i_op == scpc_pkg::OP_LOAD_COST);
    assign w_wr.cov_en  = w_accept && w_in_range && (i_op == scpc_pkg::OP_LOAD_COV);
    assign w_wr.addr    = w_idx32[scpc_pkg::SITE_AW-1:0];
    assign w_wr.cost    = w_cost32[scpc_pkg::COST_BITS-1:0];
    assign w_wr.cov     = w_cov64[scpc_pkg::NUM_CUSTOMERS-1:0];

    scpc_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_rd    (w_rd_data)
    );

    scpc_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && (i_op == scpc_pkg::OP_EVAL)),
        .i_open_mask (i_open_mask),
        .o_busy      (w_busy),
        .o_rd        (w_rd),
        .i_rd        (w_rd_data),
        .o_res       (w_res),
        .i_res_take  (w_take)
    );

    // The output register takes a new result when it is empty or being read.
    assign w_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res.valid) begin
            r_total <= w_res.total;
            r_count <= w_res.count;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_total_cost      = r_total;
    assign o_uncovered_count = r_count;

    // A finished result only exists while the request channel is closed.
    `ASSERT_NEVER(a_ready_while_result, i_clk, i_rst_n, o_in_ready && w_res.valid, "ready with result pending")
    // An accepted evaluation closes the request channel on the next cycle.
    `ASSERT_CLK(a_eval_busy, i_clk, i_rst_n, (w_accept && (i_op == scpc_pkg::OP_EVAL)) |=> !o_in_ready, "eval did not start")
    // The output register fills only from a finished evaluation.
    `ASSERT_CLK(a_out_source, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(w_res.valid), "result without eval")
    // No more customers can be missing than exist.
    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, o_out_valid |-> (32'(o_uncovered_count) <= 32'(scpc_pkg::NUM_CUSTOMERS)), "count out of range")

endmodule
